// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is asserted.
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define CRS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/crs_pkg.sv =====
// Types and constants of the Catmull-Rom evaluator.
package crs_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 17;
  localparam int unsigned WeightW = 33;
  localparam int unsigned Taps = 4;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic        [FracW-1:0]   frac_t;
  typedef logic signed [WeightW-1:0] weight_t;

  typedef coord_t  [Taps-1:0] coord4_t;
  typedef weight_t [Taps-1:0] weight4_t;

  // Tap order: before, start, end, after.
  localparam int unsigned TapBefore = 0;
  localparam int unsigned TapStart  = 1;
  localparam int unsigned TapEnd    = 2;
  localparam int unsigned TapAfter  = 3;

  localparam frac_t ONE_Q16     = 17'd65536;
  localparam frac_t TENSION_RST = 17'd32768;

  localparam logic signed [53:0] ONE_Q48   = 54'sd281474976710656;
  localparam logic signed [53:0] RND_Q30   = 54'sd131072;
  localparam logic signed [66:0] RND_Q16   = 67'sd536870912;
  localparam coord_t             COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t             COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord4_t  coord;
    weight4_t weight;
  } wt_word_t;

endpackage

// ===== design/crs_in_if.sv =====
// Input channel: four control coordinates and the curve parameter.
interface crs_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] coord_before;
  logic signed [31:0] coord_start;
  logic signed [31:0] coord_end;
  logic signed [31:0] coord_after;
  logic [16:0]       position;

  modport source (output valid, coord_before, coord_start, coord_end, coord_after,
                  position, input ready);
  modport sink   (input valid, coord_before, coord_start, coord_end, coord_after,
                  position, output ready);
endinterface

// ===== design/crs_out_if.sv =====
// Result channel: one interpolated coordinate.
interface crs_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] curve_coord;

  modport source (output valid, curve_coord, input ready);
  modport sink   (input valid, curve_coord, output ready);
endinterface

// ===== design/catmull_rom_spline_eval_unit.sv =====
// Top level of the Catmull-Rom segment evaluator with tension.
//
// Usage: send one word per axis on in_chan (four control coordinates, signed
// Q16.16, and the curve parameter position, unsigned Q1.16 with 65536 = 1.0);
// three words give a 3D point. Each word yields exactly one word on out_chan,
// curve_coord in signed Q16.16, saturated, in the order the inputs arrived.
// Both channels complete a transfer on a clock edge with valid and ready high.
// The tension is a single 17-bit register written through cfg_wr_en and
// cfg_wr_data; write it only while no word is in flight. Values of position or
// tension above 1.0 are treated as 1.0.
// Pipeline: ten register stages (six weight stages, four sum stages, the last
// being the output register). Throughput: one word per cycle while out_chan
// is not stalled, set by the fully pipelined multipliers.
// Reset (rst_n low, synchronous) empties the pipeline and loads tension 0.5.
// When the receiver stalls, words pile up in the empty slots of the pipeline;
// in_chan.ready drops only once every stage holds a word.
module catmull_rom_spline_eval_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [16:0]      cfg_wr_data,
  crs_in_if.sink           in_chan,
  crs_out_if.source        out_chan
);

  crs_pkg::frac_t    tension_r;
  crs_pkg::coord4_t  in_coord;
  crs_pkg::wt_word_t wt_word;
  logic              wt_valid;
  logic              wt_ready;

  // Hold the tension; load on every write strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= crs_pkg::TENSION_RST;
    end else if (cfg_wr_en) begin
      tension_r <= cfg_wr_data;
    end
  end

  // Pack the four control coordinates in tap order.
  assign in_coord[crs_pkg::TapBefore] = in_chan.coord_before;
  assign in_coord[crs_pkg::TapStart]  = in_chan.coord_start;
  assign in_coord[crs_pkg::TapEnd]    = in_chan.coord_end;
  assign in_coord[crs_pkg::TapAfter]  = in_chan.coord_after;

  // Front half: powers of the parameter, tension products, Q30 weights.
  crs_weight u_weight (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_chan.valid),
    .up_ready    (in_chan.ready),
    .up_coord    (in_coord),
    .up_position (in_chan.position),
    .tension     (tension_r),
    .dn_valid    (wt_valid),
    .dn_ready    (wt_ready),
    .dn_word     (wt_word)
  );

  // Back half: weighted sum, rounding and saturation into the output register.
  crs_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (wt_valid),
    .up_ready (wt_ready),
    .up_word  (wt_word),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_coord (out_chan.curve_coord)
  );

endmodule

// ===== design/crs_weight.sv =====
// Six-stage basis weight pipeline: powers of x, tension products, Q30 weights.
module crs_weight (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  crs_pkg::coord4_t  up_coord,
  input  crs_pkg::frac_t    up_position,
  input  crs_pkg::frac_t    tension,
  output logic              dn_valid,
  input  logic              dn_ready,
  output crs_pkg::wt_word_t dn_word
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] vld_r;
  logic [NStg:0]   rdy;

  crs_pkg::coord4_t crd_r [NStg];

  // stage 1
  crs_pkg::frac_t x_s1_r, t_s1_r;
  logic [32:0]    x2_s1_r, tx_s1_r;
  // stage 2
  crs_pkg::frac_t t_s2_r;
  logic [32:0]    x2_s2_r, tx_s2_r;
  logic [48:0]    x3_s2_r, tx2_s2_r;
  // stage 3
  logic [32:0]    x2_s3_r, tx_s3_r, txl_s3_r;
  logic [48:0]    x3_s3_r, tx2_s3_r, txh_s3_r;
  // stage 4
  logic [32:0]    x2_s4_r, tx_s4_r;
  logic [48:0]    x3_s4_r, tx2_s4_r, tx3_s4_r;
  // stage 5 and 6
  logic signed [53:0] w48_s5_r [crs_pkg::Taps];
  crs_pkg::weight4_t  wq_s6_r;

  crs_pkg::frac_t     x_nxt, t_nxt;
  logic signed [53:0] e_tx, e_x2q, e_x3, e_tx2, e_tx3;
  logic signed [53:0] w48_nxt [crs_pkg::Taps];
  logic signed [53:0] wr;
  crs_pkg::weight4_t  wq_nxt;

  // Ready ripples back from the output: a stage loads when empty or draining.
  always_comb begin
    rdy[NStg] = dn_ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[NStg-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    x_nxt = (up_position > crs_pkg::ONE_Q16) ? crs_pkg::ONE_Q16 : up_position;
    t_nxt = (tension > crs_pkg::ONE_Q16) ? crs_pkg::ONE_Q16 : tension;
  end

  // Lift every term to Q48 and form the four weights.
  always_comb begin
    e_tx  = $signed({5'b0, tx_s4_r, 16'b0});
    e_x2q = $signed({5'b0, x2_s4_r, 16'b0});
    e_x3  = $signed({5'b0, x3_s4_r});
    e_tx2 = $signed({5'b0, tx2_s4_r});
    e_tx3 = $signed({5'b0, tx3_s4_r});
    w48_nxt[crs_pkg::TapBefore] = (e_tx2 <<< 1) - e_tx - e_tx3;
    w48_nxt[crs_pkg::TapStart]  = crs_pkg::ONE_Q48 + e_tx2 - (e_x2q <<< 1) - e_x2q
                                  + (e_x3 <<< 1) - e_tx3;
    w48_nxt[crs_pkg::TapEnd]    = e_tx + (e_x2q <<< 1) + e_x2q - (e_tx2 <<< 1)
                                  + e_tx3 - (e_x3 <<< 1);
    w48_nxt[crs_pkg::TapAfter]  = e_tx3 - e_tx2;
  end

  // Round half up to Q30; every weight stays well inside two.
  always_comb begin
    wr = '0;
    for (int k = 0; k < crs_pkg::Taps; k++) begin
      wr        = w48_s5_r[k] + crs_pkg::RND_Q30;
      wq_nxt[k] = wr[50:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      crd_r[0] <= up_coord;
      x_s1_r   <= x_nxt;
      t_s1_r   <= t_nxt;
      x2_s1_r  <= 33'(x_nxt) * 33'(x_nxt);
      tx_s1_r  <= 33'(t_nxt) * 33'(x_nxt);
    end
    if (rdy[1]) begin
      crd_r[1] <= crd_r[0];
      t_s2_r   <= t_s1_r;
      x2_s2_r  <= x2_s1_r;
      tx_s2_r  <= tx_s1_r;
      x3_s2_r  <= 49'(x2_s1_r) * 49'(x_s1_r);
      tx2_s2_r <= 49'(t_s1_r) * 49'(x2_s1_r);
    end
    if (rdy[2]) begin
      crd_r[2] <= crd_r[1];
      x2_s3_r  <= x2_s2_r;
      tx_s3_r  <= tx_s2_r;
      x3_s3_r  <= x3_s2_r;
      tx2_s3_r <= tx2_s2_r;
      // t*x^3 in two halves keeps each product near 17 by 33 bits.
      txh_s3_r <= 49'(t_s2_r) * 49'(x3_s2_r[48:16]);
      txl_s3_r <= 33'(t_s2_r) * 33'(x3_s2_r[15:0]);
    end
    if (rdy[3]) begin
      crd_r[3] <= crd_r[2];
      x2_s4_r  <= x2_s3_r;
      tx_s4_r  <= tx_s3_r;
      x3_s4_r  <= x3_s3_r;
      tx2_s4_r <= tx2_s3_r;
      tx3_s4_r <= txh_s3_r + 49'(txl_s3_r[32:16]);
    end
    if (rdy[4]) begin
      crd_r[4] <= crd_r[3];
      w48_s5_r <= w48_nxt;
    end
    if (rdy[5]) begin
      crd_r[5] <= crd_r[4];
      wq_s6_r  <= wq_nxt;
    end
  end

  assign dn_word.coord  = crd_r[NStg-1];
  assign dn_word.weight = wq_s6_r;

endmodule

// ===== design/crs_dot.sv =====
// Four-stage weighted sum: products, adder tree, round and saturate.
module crs_dot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  crs_pkg::wt_word_t up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output crs_pkg::coord_t   dn_coord
);

  localparam int unsigned NStg = 4;

  logic [NStg-1:0] vld_r;
  logic [NStg:0]   rdy;

  logic signed [64:0] p_r [crs_pkg::Taps];
  logic signed [65:0] s01_r, s23_r;
  logic signed [66:0] acc_r;
  crs_pkg::coord_t    res_r;

  logic signed [64:0] p_nxt [crs_pkg::Taps];
  logic signed [66:0] accr;
  logic signed [36:0] r37;
  crs_pkg::coord_t    res_nxt;

  always_comb begin
    rdy[NStg] = dn_ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[NStg-1];
  assign dn_coord = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < crs_pkg::Taps; k++) begin
      p_nxt[k] = 65'($signed(up_word.coord[k])) * 65'($signed(up_word.weight[k]));
    end
  end

  // Round half up from Q46 to Q16.16, then clip to the 32-bit range.
  always_comb begin
    accr = acc_r + crs_pkg::RND_Q16;
    r37  = accr[66:30];
    if (r37 > 37'(crs_pkg::COORD_MAX)) begin
      res_nxt = crs_pkg::COORD_MAX;
    end else if (r37 < 37'(crs_pkg::COORD_MIN)) begin
      res_nxt = crs_pkg::COORD_MIN;
    end else begin
      res_nxt = r37[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_r <= p_nxt;
    end
    if (rdy[1]) begin
      s01_r <= 66'(p_r[crs_pkg::TapBefore]) + 66'(p_r[crs_pkg::TapStart]);
      s23_r <= 66'(p_r[crs_pkg::TapEnd]) + 66'(p_r[crs_pkg::TapAfter]);
    end
    if (rdy[2]) begin
      acc_r <= 67'(s01_r) + 67'(s23_r);
    end
    if (rdy[3]) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== design/crs_checker.sv =====
// Port-level checks of the evaluator, bound to the top level.
`include "assert_macros.svh"

module crs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_curve_coord
);

  // A stalled result word holds its value.
  `CRS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_curve_coord), "stalled result changed or vanished")

  // The input backs up only when the output is stalled with a word waiting.
  `CRS_ASSERT(a_full_stall, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input blocked without an output stall")

  // Reset empties the pipeline and opens the input.
  `CRS_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")

  // An input word is blocked only while a result word waits at the output.
  `CRS_ASSERT(a_in_blocked, clk, rst_n, in_valid && !in_ready |-> out_valid, "input blocked with nothing to drain")

endmodule

bind catmull_rom_spline_eval_unit crs_checker u_crs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_curve_coord (out_chan.curve_coord)
);

// ===== tb/sv/tb_catmull_rom_spline_eval_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Catmull-Rom segment evaluator with tension.
module tb_catmull_rom_spline_eval_unit;

  // Wide enough for every intermediate product of the basis weights and the sum.
  typedef logic signed [79:0] wide_t;

  // One input word: the four control coordinates of one axis and the parameter.
  typedef struct {
    crs_pkg::coord_t coord_before;
    crs_pkg::coord_t coord_start;
    crs_pkg::coord_t coord_end;
    crs_pkg::coord_t coord_after;
    crs_pkg::frac_t  position;
  } spline_word_t;

  localparam int unsigned    CYCLE_LIMIT = 200000;
  localparam int unsigned    LATENCY     = 10;
  localparam int unsigned    HOLD_OFF    = 300;
  localparam int unsigned    RANDOM_WORDS = 1500;
  localparam int unsigned    PHASES      = 10;
  localparam crs_pkg::frac_t FRAC_MAX    = 17'h1ffff;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  crs_in_if  in_if ();
  crs_out_if out_if ();

  catmull_rom_spline_eval_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  // Expected curve coordinates, oldest first, and our copy of the tension register.
  crs_pkg::coord_t curve_q[$];
  crs_pkg::frac_t  tension_now;

  int          fails;
  int          words_sent;
  int          words_checked;
  int          settings_used;
  int unsigned cycles;

  // Idling switches for each side, and the receiver's stall counters.
  bit          send_idle;
  bit          recv_idle;
  int          recv_stall;
  int          hold_left;

  // 8 ns clock: high for 4, low for 4.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Clamp a Q1.16 value to 1.0, as the block does for position and tension.
  function automatic crs_pkg::frac_t frac_clamp(crs_pkg::frac_t v);
    return (v > crs_pkg::ONE_Q16) ? crs_pkg::ONE_Q16 : v;
  endfunction

  // Predict the curve coordinate of one word under tension ten.
  // Weights are built in Q48 (t*x^3 truncated), rounded half up to Q30; the
  // weighted sum is kept exactly in Q46, rounded half up to Q16.16, then saturated.
  function automatic crs_pkg::coord_t eval_segment(spline_word_t wd, crs_pkg::frac_t ten);
    wide_t           x, t, x2, x3, tx, tx2, tx3, x2q, acc, wq, cw, r;
    wide_t           basis[4];
    crs_pkg::coord_t taps[4];
    x   = frac_clamp(wd.position);
    t   = frac_clamp(ten);
    x2  = x * x;             // Q32
    x3  = x2 * x;            // Q48
    tx  = (t * x) <<< 16;    // Q48
    tx2 = t * x2;            // Q48
    tx3 = (t * x3) >>> 16;   // Q48, truncated (operands are non-negative)
    x2q = x2 <<< 16;         // Q48
    basis[0] = -tx + 2 * tx2 - tx3;
    basis[1] = (wide_t'(1) <<< 48) + tx2 - 3 * x2q + 2 * x3 - tx3;
    basis[2] = tx + 3 * x2q - 2 * tx2 + tx3 - 2 * x3;
    basis[3] = -tx2 + tx3;
    taps[crs_pkg::TapBefore] = wd.coord_before;
    taps[crs_pkg::TapStart]  = wd.coord_start;
    taps[crs_pkg::TapEnd]    = wd.coord_end;
    taps[crs_pkg::TapAfter]  = wd.coord_after;
    acc = '0;
    for (int k = 0; k < crs_pkg::Taps; k++) begin
      wq  = (basis[k] + (wide_t'(1) <<< 17)) >>> 18;
      cw  = taps[k];
      acc = acc + cw * wq;
    end
    r = (acc + (wide_t'(1) <<< 29)) >>> 30;
    if (r > wide_t'(crs_pkg::COORD_MAX)) begin
      return crs_pkg::COORD_MAX;
    end
    if (r < wide_t'(crs_pkg::COORD_MIN)) begin
      return crs_pkg::COORD_MIN;
    end
    return r[31:0];
  endfunction

  function automatic spline_word_t make_word(crs_pkg::coord_t b, crs_pkg::coord_t s,
                                             crs_pkg::coord_t e, crs_pkg::coord_t a,
                                             crs_pkg::frac_t p);
    spline_word_t wd;
    wd.coord_before = b;
    wd.coord_start  = s;
    wd.coord_end    = e;
    wd.coord_after  = a;
    wd.position     = p;
    return wd;
  endfunction

  // Mix of full-range, bound and small coordinates; small ones keep the sum in
  // range so most results are not saturated.
  function automatic crs_pkg::coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return crs_pkg::COORD_MAX;
      1:       return crs_pkg::COORD_MIN;
      2, 3:    return crs_pkg::coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return crs_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly inside [0, 1], with the ends and values above one now and then.
  function automatic crs_pkg::frac_t rand_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return crs_pkg::ONE_Q16;
      2:       return crs_pkg::frac_t'($urandom_range(65537, 131071));
      default: return crs_pkg::frac_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic spline_word_t rand_word();
    return make_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_fraction());
  endfunction

  // Offer one word and hold it until the block takes it. Inputs change on the
  // falling edge; acceptance is seen on the rising edge. Valid stays high on
  // return, so the caller either sends the next word or drops valid with
  // drain_words before time moves on.
  task automatic send_word(spline_word_t wd);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.coord_before <= wd.coord_before;
    in_if.coord_start  <= wd.coord_start;
    in_if.coord_end    <= wd.coord_end;
    in_if.coord_after  <= wd.coord_after;
    in_if.position     <= wd.position;
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    curve_q.push_back(eval_segment(wd, tension_now));
    words_sent++;
  endtask

  // Drop valid and wait until every expected word has come back. Each word
  // yields exactly one result, so an empty queue means an empty pipeline.
  task automatic drain_words();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
  endtask

  // Write the tension register, only once the pipeline is empty.
  task automatic write_tension(crs_pkg::frac_t v);
    drain_words();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tension_now = v;
    settings_used++;
  endtask

  // Receiver: hold ready low through a requested hold-off, then through the
  // stall drawn for the last word, else keep it high.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (recv_stall > 0) begin
      out_if.ready <= 1'b0;
      recv_stall   <= recv_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    crs_pkg::coord_t expected;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (curve_q.size() == 0) begin
        $error("curve_coord: no word expected, got %0d", out_if.curve_coord);
        fails++;
      end else begin
        expected = curve_q.pop_front();
        if (out_if.curve_coord !== expected) begin
          $error("curve_coord: expected %0d, got %0d", expected, out_if.curve_coord);
          fails++;
        end
        words_checked++;
      end
      recv_stall <= recv_idle ? $urandom_range(0, 6) : 0;
    end
  end

  // Watchdog: end the run if it overruns the cycle budget.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // At the reset tension of 0.5: zero input, both segment ends, the midpoint.
  task automatic test_reset_tension();
    send_word(make_word(32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'd0));
    send_word(make_word(32'sd65536, 32'sd131072, -32'sd196608, 32'sd262144, 17'd0));
    send_word(make_word(32'sd65536, 32'sd131072, -32'sd196608, 32'sd262144,
                        crs_pkg::ONE_Q16));
    send_word(make_word(-32'sd65536, 32'sd65536, 32'sd131072, -32'sd131072, 17'd32768));
    drain_words();
  endtask

  // Tension and position at their extremes, including values above one, and
  // coordinates at both bounds.
  task automatic test_extremes();
    write_tension(17'd0);
    send_word(make_word(crs_pkg::COORD_MAX, 32'sd12345, -32'sd54321, crs_pkg::COORD_MIN,
                        17'd21845));
    send_word(make_word(crs_pkg::COORD_MIN, crs_pkg::COORD_MIN, crs_pkg::COORD_MIN,
                        crs_pkg::COORD_MIN, 17'd1));
    write_tension(crs_pkg::ONE_Q16);
    send_word(make_word(crs_pkg::COORD_MAX, crs_pkg::COORD_MAX, crs_pkg::COORD_MAX,
                        crs_pkg::COORD_MAX, 17'd49152));
    send_word(make_word(crs_pkg::COORD_MIN, crs_pkg::COORD_MIN, crs_pkg::COORD_MIN,
                        crs_pkg::COORD_MIN, 17'd65535));
    send_word(make_word(32'sd1, -32'sd1, 32'sd1, -32'sd1, FRAC_MAX));
    // Above one for tension: the block must treat it as exactly one.
    write_tension(FRAC_MAX);
    send_word(make_word(32'sd100000, -32'sd200000, 32'sd300000, -32'sd400000, 17'd16384));
    send_word(make_word(32'sd7, 32'sd70000, -32'sd70000, 32'sd7, 17'd65537));
    send_word(make_word(crs_pkg::COORD_MAX, crs_pkg::COORD_MIN, crs_pkg::COORD_MAX,
                        crs_pkg::COORD_MIN, 17'd98304));
    drain_words();
  endtask

  // Overshooting control points drive the sum past both bounds.
  task automatic test_saturation();
    write_tension(crs_pkg::ONE_Q16);
    send_word(make_word(crs_pkg::COORD_MIN, crs_pkg::COORD_MAX, crs_pkg::COORD_MAX,
                        crs_pkg::COORD_MIN, 17'd32768));
    send_word(make_word(crs_pkg::COORD_MAX, crs_pkg::COORD_MIN, crs_pkg::COORD_MIN,
                        crs_pkg::COORD_MAX, 17'd32768));
    send_word(make_word(crs_pkg::COORD_MIN, crs_pkg::COORD_MAX, crs_pkg::COORD_MAX,
                        crs_pkg::COORD_MIN, 17'd20000));
    send_word(make_word(crs_pkg::COORD_MAX, crs_pkg::COORD_MIN, crs_pkg::COORD_MIN,
                        crs_pkg::COORD_MAX, 17'd45000));
    drain_words();
  endtask

  // Hold the receiver off for a long stretch while the sender streams back to
  // back, so the pipeline fills and in_chan.ready drops.
  task automatic test_backpressure();
    write_tension(crs_pkg::frac_t'($urandom_range(0, 65536)));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_left = HOLD_OFF;
    repeat (80) send_word(rand_word());
    drain_words();
  endtask

  // Random words over several tension settings, with idling switched on and
  // off per side so some phases run at full rate.
  task automatic test_random();
    crs_pkg::frac_t ten;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       ten = '0;
        1:       ten = crs_pkg::ONE_Q16;
        2:       ten = FRAC_MAX;
        3:       ten = crs_pkg::TENSION_RST;
        4:       ten = crs_pkg::frac_t'($urandom_range(65537, 131071));
        default: ten = crs_pkg::frac_t'($urandom_range(0, 65536));
      endcase
      write_tension(ten);
      send_idle = (ph % 3) != 0;
      recv_idle = (ph % 4) != 1;
      repeat (RANDOM_WORDS / PHASES) send_word(rand_word());
    end
    drain_words();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_if.valid        = 1'b0;
    in_if.coord_before = '0;
    in_if.coord_start  = '0;
    in_if.coord_end    = '0;
    in_if.coord_after  = '0;
    in_if.position     = '0;
    out_if.ready       = 1'b0;
    recv_stall         = 0;
    hold_left          = 0;
    fails              = 0;
    words_sent         = 0;
    words_checked      = 0;
    settings_used      = 1;
    tension_now        = crs_pkg::TENSION_RST;
    send_idle          = 1'b1;
    recv_idle          = 1'b1;

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_tension();
    test_extremes();
    test_saturation();
    test_backpressure();
    test_random();

    // Let the pipeline run out in case a stray word is still on its way.
    drain_words();
    repeat (LATENCY + 2) @(posedge clk);

    $display("Checked %0d curve words of %0d sent across %0d tension settings,",
             words_checked, words_sent, settings_used);
    $display("with random idling on both channels and a %0d-cycle output hold-off.",
             HOLD_OFF);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/crs_pkg.sv
design/crs_in_if.sv
design/crs_out_if.sv
design/crs_weight.sv
design/crs_dot.sv
design/catmull_rom_spline_eval_unit.sv
design/crs_checker.sv
tb/sv/tb_catmull_rom_spline_eval_unit.sv
